// ===== rtl/wrzsd_pkg.sv =====
// Package for the window range zero speed detector.
// Holds register indexes, config port widths and the control state type.
// No dependencies.
package wrzsd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WLEN_W     = 7;
  localparam int DELTA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA  = 2'd1;

  localparam logic [WLEN_W-1:0]  WLEN_RESET  = 7'd64;
  localparam logic [DELTA_W-1:0] DELTA_RESET = 32'd0;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

endpackage

// ===== rtl/window_range_zero_speed_detector.sv =====
// The result beat of an accepted sample is loaded when its sweep ends, once the
// min/max pair has walked the cell chain one cell per cycle. No new sample is
// taken until the result beat is loaded; a waiting result beat stalls the next.
// A result may wait in the output register while the next sample is taken.
// Reset (rst_n low, synchronous): window_len 64, max_delta 0, window empty;
// stored samples are not cleared. Built from wrzsd_cell and wrzsd_pkg.
module window_range_zero_speed_detector #(
  parameter int MAX_WINDOW = 64,
  parameter int POS_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [POS_WIDTH-1:0]            in_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_zero_speed,
  input  logic                            cfg_we,
  input  logic [wrzsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrzsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wrzsd_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
  localparam int DIFF_W = ((POS_WIDTH + 1) > (DELTA_W + 1)) ? (POS_WIDTH + 1) : (DELTA_W + 1);

  state_t              state_r, state_nxt;
  logic [WLEN_W-1:0]   window_len_r;
  logic [DELTA_W-1:0]  max_delta_r;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic                full_r;
  logic [LEN_W-1:0]    sweep_cnt_r;
  logic                out_valid_r;
  logic                out_zero_speed_r;

  logic [CMP_W-1:0]    wl_ext;
  logic [LEN_W-1:0]    eff_len;
  logic                in_acc;
  logic                sweep_done;
  logic                load_out;
  logic [POS_WIDTH:0]  spread;
  logic                spread_ok;

  logic [POS_WIDTH-1:0] sample_w [0:MAX_WINDOW];
  logic [POS_WIDTH-1:0] lo_w     [0:MAX_WINDOW];
  logic [POS_WIDTH-1:0] hi_w     [0:MAX_WINDOW];

  // Clamp the programmed length into 2..MAX_WINDOW.
  assign wl_ext = CMP_W'(window_len_r);
  always_comb begin
    if (wl_ext < CMP_W'(2)) begin
      eff_len = LEN_W'(2);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wl_ext);
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign sweep_done = (state_r == ST_SWEEP && sweep_cnt_r == LEN_W'(MAX_WINDOW))
                      || (state_r == ST_HOLD);
  assign load_out   = sweep_done && (!out_valid_r || out_ready);

  // Cell chain: newest sample enters cell 0, min/max pair seeded at cell 0.
  assign sample_w[0] = in_position;
  assign lo_w[0]     = {1'b0, {(POS_WIDTH-1){1'b1}}};
  assign hi_w[0]     = {1'b1, {(POS_WIDTH-1){1'b0}}};

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    wrzsd_cell #(
      .W     (POS_WIDTH),
      .LEN_W (LEN_W),
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .shift_en   (in_acc),
      .eff_len    (eff_len),
      .sample_in  (sample_w[g]),
      .sample_out (sample_w[g+1]),
      .lo_in      (lo_w[g]),
      .hi_in      (hi_w[g]),
      .lo_out     (lo_w[g+1]),
      .hi_out     (hi_w[g+1])
    );
  end

  // Spread is hi - lo, exact in POS_WIDTH + 1 bits.
  assign spread = {hi_w[MAX_WINDOW][POS_WIDTH-1], hi_w[MAX_WINDOW]}
                - {lo_w[MAX_WINDOW][POS_WIDTH-1], lo_w[MAX_WINDOW]};
  assign spread_ok = (DIFF_W'(spread) <= DIFF_W'(max_delta_r));

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_we && cfg_index == REG_WINDOW_LEN) begin
      fill_nxt = '0;
    end else if (in_acc) begin
      if (fill_r < eff_len) fill_nxt = fill_r + LEN_W'(1);
      else                  fill_nxt = eff_len;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_done) state_nxt = load_out ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_len_r <= WLEN_RESET;
      max_delta_r  <= DELTA_RESET;
      fill_r       <= '0;
      full_r       <= 1'b0;
      sweep_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: window_len_r <= cfg_wdata[WLEN_W-1:0];
          REG_MAX_DELTA:  max_delta_r  <= cfg_wdata[DELTA_W-1:0];
          default:        ;
        endcase
      end
      if (in_acc) begin
        full_r      <= (fill_nxt >= eff_len);
        sweep_cnt_r <= '0;
      end else if (state_r == ST_SWEEP && !sweep_done) begin
        sweep_cnt_r <= sweep_cnt_r + LEN_W'(1);
      end
      // Hold the result beat until taken.
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_zero_speed_r <= full_r && spread_ok;
  end

  assign out_valid      = out_valid_r;
  assign out_zero_speed = out_zero_speed_r;

  a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SWEEP)
    else $error("accepted sample did not start a sweep");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= eff_len)
    else $error("fill count beyond window length");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> sweep_cnt_r <= LEN_W'(MAX_WINDOW))
    else $error("sweep counter overran the chain");

  a_result_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |->
      $past(state_r) == ST_SWEEP || $past(state_r) == ST_HOLD)
    else $error("result beat appeared without a finished sweep");

endmodule

// ===== rtl/wrzsd_cell.sv =====
// One cell of the sample chain: holds one position sample and folds it into
// the running min/max pair that travels down the chain. Uses no package items.
module wrzsd_cell #(
  parameter int W     = 32,
  parameter int LEN_W = 7,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [LEN_W-1:0] eff_len,
  input  logic [W-1:0]     sample_in,
  output logic [W-1:0]     sample_out,
  input  logic [W-1:0]     lo_in,
  input  logic [W-1:0]     hi_in,
  output logic [W-1:0]     lo_out,
  output logic [W-1:0]     hi_out
);

  logic [W-1:0] sample_r;
  logic [W-1:0] lo_r, lo_nxt;
  logic [W-1:0] hi_r, hi_nxt;
  logic         in_window;

  // Cells past the window length pass the pair through untouched.
  assign in_window = (LEN_W'(INDEX) < eff_len);

  always_comb begin
    lo_nxt = lo_in;
    hi_nxt = hi_in;
    if (in_window) begin
      if ($signed(sample_r) < $signed(lo_in)) lo_nxt = sample_r;
      if ($signed(sample_r) > $signed(hi_in)) hi_nxt = sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) sample_r <= sample_in;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign sample_out = sample_r;
  assign lo_out     = lo_r;
  assign hi_out     = hi_r;

endmodule
